// ===== src/ffia_pkg.sv =====
`default_nettype none

package ffia_pkg;

    // Default number of slots in storage.
    localparam int SLOTS_DEFAULT = 16;

    // Reset value of the slots-in-use register.
    localparam logic [4:0] SLOTS_IN_USE_RESET = 5'd16;

    // The granted count saturates here.
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [31:0] start_time;
        logic [31:0] end_time;
        logic        first_request;
        logic        last_request;
    } ffia_req_t;

    typedef struct packed {
        logic        granted;
        logic [3:0]  slot_index;
        logic [15:0] granted_total;
        logic        run_done;
    } ffia_rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } ffia_state_t;

endpackage

`default_nettype wire

// ===== src/ffia_ram.sv =====
`default_nettype none

module ffia_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== src/ffia_seq.sv =====
`default_nettype none

module ffia_seq #(
    parameter int SLOTS = ffia_pkg::SLOTS_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_take,
    input  wire ffia_pkg::ffia_req_t req,
    input  wire logic [4:0]        slots_in_use,
    output logic                   busy,
    output logic                   res_valid,
    input  wire logic              res_take,
    output ffia_pkg::ffia_rsp_t    res
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    ffia_pkg::ffia_state_t state_reg;
    ffia_pkg::ffia_state_t state_next;

    logic [CNT_W-1:0] issue_idx_reg;
    logic [CNT_W-1:0] cmp_idx_reg;
    logic             cmp_pend_reg;
    logic [CNT_W-1:0] active_reg;
    logic [31:0]      start_reg;
    logic [31:0]      end_reg;
    logic             last_reg;
    logic [SLOTS-1:0] valid_reg;
    logic [15:0]      count_reg;
    logic             found_reg;
    logic [IDX_W-1:0] pick_reg;

    logic [CNT_W-1:0] active_calc;
    logic             rd_en;
    logic [31:0]      rd_data;
    logic [31:0]      rd_val;
    logic             hit;
    logic             last_cmp;

    // Slots beyond the storage size do not take part.
    always_comb
    begin
        if ({27'd0, slots_in_use} > 32'(SLOTS))
        begin
            active_calc = CNT_W'(SLOTS);
        end
        else
        begin
            active_calc = CNT_W'(slots_in_use);
        end
    end

    // A slot never written since the last clear reads as release time zero.
    assign rd_val   = valid_reg[cmp_idx_reg[IDX_W-1:0]] ? rd_data : 32'd0;
    assign hit      = cmp_pend_reg && (rd_val < start_reg);
    assign last_cmp = cmp_pend_reg && ((cmp_idx_reg + CNT_W'(1)) == active_reg);

    ffia_ram #(
        .WIDTH (32),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (hit && (state_reg == ffia_pkg::ST_SCAN)),
        .wr_addr (cmp_idx_reg[IDX_W-1:0]),
        .wr_data (end_reg),
        .rd_en   (rd_en),
        .rd_addr (issue_idx_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ffia_pkg::ST_IDLE:
            begin
                if (req_take)
                begin
                    state_next = (active_calc == '0) ? ffia_pkg::ST_DONE : ffia_pkg::ST_SCAN;
                end
            end
            ffia_pkg::ST_SCAN:
            begin
                if (hit || last_cmp)
                begin
                    state_next = ffia_pkg::ST_DONE;
                end
            end
            ffia_pkg::ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ffia_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ffia_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy      = 1'b1;
        res_valid = 1'b0;
        rd_en     = 1'b0;
        unique case (state_reg)
            ffia_pkg::ST_IDLE:
            begin
                busy = 1'b0;
            end
            ffia_pkg::ST_SCAN:
            begin
                rd_en = (issue_idx_reg < active_reg);
            end
            ffia_pkg::ST_DONE:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ffia_pkg::ST_IDLE;
            cmp_pend_reg <= 1'b0;
            valid_reg    <= '0;
            count_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ffia_pkg::ST_IDLE && req_take)
            begin
                cmp_pend_reg <= 1'b0;
                if (req.first_request)
                begin
                    valid_reg <= '0;
                    count_reg <= '0;
                end
            end
            else if (state_reg == ffia_pkg::ST_SCAN)
            begin
                cmp_pend_reg <= rd_en && !hit;
                if (hit)
                begin
                    valid_reg[cmp_idx_reg[IDX_W-1:0]] <= 1'b1;
                    if (count_reg != ffia_pkg::COUNT_MAX)
                    begin
                        count_reg <= count_reg + 16'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ffia_pkg::ST_IDLE && req_take)
        begin
            start_reg     <= req.start_time;
            end_reg       <= req.end_time;
            last_reg      <= req.last_request;
            active_reg    <= active_calc;
            issue_idx_reg <= '0;
            found_reg     <= 1'b0;
            pick_reg      <= '0;
        end
        else if (state_reg == ffia_pkg::ST_SCAN)
        begin
            if (rd_en)
            begin
                issue_idx_reg <= issue_idx_reg + CNT_W'(1);
            end
            cmp_idx_reg <= issue_idx_reg;
            if (hit)
            begin
                found_reg <= 1'b1;
                pick_reg  <= cmp_idx_reg[IDX_W-1:0];
            end
        end
    end

    // The pick stays zero for a refused request.
    always_comb
    begin
        res.granted       = found_reg;
        res.slot_index    = 4'(pick_reg);
        res.granted_total = count_reg;
        res.run_done      = last_reg;
    end

endmodule

`default_nettype wire

// ===== src/first_fit_interval_allocator_top.sv =====
// First-fit interval allocator.
//
// Requests (start time, end time, first and last flags) enter on the req
// channel and are accepted on a rising edge with req_valid high and
// req_stall low. Each request is answered by exactly one response on the rsp
// channel, taken on an edge with rsp_valid high and rsp_stall low.
// The slots-in-use register is written through cfg_valid/cfg_ready/cfg_data;
// cfg_ready is always high, and the register should change only while the
// block is idle.
//
// A request scans the release times of the active slots one per cycle through
// a single 32-bit comparator fed by a registered-read slot memory. The scan
// stops at the first slot whose release time is below the start time, or at
// the last active slot. A new request is not accepted before the response to
// the last one is loaded; it can be accepted in the cycle after that. At
// reset all slots read as free with release time zero, the count is zero,
// and slots-in-use is 16. When the receiver stalls, a finished response
// waits in the output register while the next request is still accepted and
// scanned; only its own response then waits for the register.
`default_nettype none

module first_fit_interval_allocator_top #(
    parameter int SLOTS = ffia_pkg::SLOTS_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire ffia_pkg::ffia_req_t req,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output ffia_pkg::ffia_rsp_t      rsp,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [4:0]          cfg_data
);

    logic [4:0]          slots_in_use_reg;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    ffia_pkg::ffia_rsp_t rsp_reg;

    logic                busy;
    logic                res_valid;
    logic                res_take;
    ffia_pkg::ffia_rsp_t res;

    assign cfg_ready = 1'b1;
    assign req_stall = busy;

    // The output register loads when it is empty or being emptied this cycle.
    assign res_take = res_valid && (!rsp_valid_reg || !rsp_stall);

    ffia_seq #(
        .SLOTS (SLOTS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_take     (req_valid && !busy),
        .req          (req),
        .slots_in_use (slots_in_use_reg),
        .busy         (busy),
        .res_valid    (res_valid),
        .res_take     (res_take),
        .res          (res)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        priority if (res_take)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_in_use_reg <= ffia_pkg::SLOTS_IN_USE_RESET;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                slots_in_use_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire
